// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
// Depends on nothing; included by snpd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication that is switched off while reset is held.
`define SNPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("snpd assertion failed");

`endif

// ===== hdl/snpd_pkg.sv =====
// Widths, region codes and beat types for the segment nearest point block.
// Depends on nothing; imported by the top level and the checker.
package snpd_pkg;

  localparam int CW    = 24;          // coordinate width
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int PW    = 2 * DW;      // product of two differences
  localparam int SW    = PW + 1;      // sum of two products
  localparam int LW    = 2 * CW + 1;  // squared length and clamped dot
  localparam int QW    = CW;          // projection quotient
  localparam int NW    = LW + CW;     // dividend
  localparam int RW    = LW + 1;      // divider partial remainder
  localparam int LO_W  = (LW + 1) / 2;
  localparam int HI_W  = LW - LO_W;
  localparam int RADW  = CW - 1;
  localparam int RSQW  = 2 * RADW;
  localparam int DISTW = 49;

  localparam logic [1:0] REGION_START    = 2'd0;
  localparam logic [1:0] REGION_END      = 2'd1;
  localparam logic [1:0] REGION_INTERIOR = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t            start_x;
    coord_t            start_y;
    coord_t            end_x;
    coord_t            end_y;
    coord_t            point_x;
    coord_t            point_y;
    logic [RADW-1:0]   radius;
  } in_t;

  typedef struct packed {
    coord_t            nearest_x;
    coord_t            nearest_y;
    logic [1:0]        region;
    logic [DISTW-1:0]  dist_squared;
    logic              hits_disc;
  } out_t;

endpackage

// ===== hdl/segment_nearest_point_disc_test.sv =====
// Takes one beat per cycle unless the output stalls; a 24-step pipelined restoring
// divider per axis sets the depth, with one quotient bit per stage.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on snpd_pkg.
module segment_nearest_point_disc_test (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  snpd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output snpd_pkg::out_t out_data_o
);
  import snpd_pkg::*;

  typedef struct packed {
    coord_t           base_x;
    coord_t           base_y;
    coord_t           px;
    coord_t           py;
    logic [RSQW-1:0]  rsq;
    logic [1:0]       region;
    logic             interior;
    logic             negx;
    logic             negy;
    logic [LW-1:0]    len;
  } carry_t;

  function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic nbit,
                                           logic [LW-1:0] len);
    logic [RW-1:0] trial;
    trial = {rem[RW-2:0], nbit};
    if (trial >= RW'(len)) begin
      div_step = {1'b1, trial - RW'(len)};
    end else begin
      div_step = {1'b0, trial};
    end
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, va_q, vb_q, vc_q, vo_q;
  logic [QW:0] dv_v_q;

  // Stage 1: differences.
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  coord_t s1_sx_q, s1_sy_q, s1_ex_q, s1_ey_q, s1_px_q, s1_py_q;
  logic [RADW-1:0] s1_rad_q;

  // Stage 2: products.
  logic signed [PW-1:0] s2_pa_q, s2_pb_q, s2_pc_q, s2_pd_q, s2_pe_q, s2_pf_q;
  logic signed [DW-1:0] s2_dx_q, s2_dy_q;
  coord_t s2_sx_q, s2_sy_q, s2_ex_q, s2_ey_q, s2_px_q, s2_py_q;
  logic [RSQW-1:0] s2_rsq_q;

  // Stage 3: region decision.
  logic signed [SW-1:0] dot1, dot2, len2;
  carry_t s3_c_d, s3_c_q;
  logic [LW-1:0] s3_dot_q;
  logic [CW-1:0] s3_magx_q, s3_magy_q;

  // Stage 4: partial products of the dividend.
  logic [LO_W+CW-1:0] s4_lox_q, s4_loy_q;
  logic [HI_W+CW-1:0] s4_hix_q, s4_hiy_q;
  carry_t s4_c_q;

  logic [NW-1:0] numx, numy;

  // Divider stages; index 0 holds the loaded dividend.
  logic [RW-1:0] dv_remx_q [QW+1];
  logic [RW-1:0] dv_remy_q [QW+1];
  logic [QW-1:0] dv_lowx_q [QW+1];
  logic [QW-1:0] dv_lowy_q [QW+1];
  logic [QW-1:0] dv_qx_q   [QW+1];
  logic [QW-1:0] dv_qy_q   [QW+1];
  carry_t        dv_c_q    [QW+1];

  // Stage A: nearest point.
  carry_t cf;
  logic signed [DW-1:0] offx, offy;
  coord_t na_x_d, na_y_d;
  coord_t sa_nx_q, sa_ny_q, sa_px_q, sa_py_q;
  logic [RSQW-1:0] sa_rsq_q;
  logic [1:0] sa_region_q;

  // Stage B: distance components.
  logic signed [DW-1:0] sb_ddx_q, sb_ddy_q;
  coord_t sb_nx_q, sb_ny_q;
  logic [RSQW-1:0] sb_rsq_q;
  logic [1:0] sb_region_q;

  // Stage C: squares.
  logic signed [PW-1:0] sc_sqx_q, sc_sqy_q;
  coord_t sc_nx_q, sc_ny_q;
  logic [RSQW-1:0] sc_rsq_q;
  logic [1:0] sc_region_q;

  logic [SW-1:0] dsq;
  out_t out_d, out_q;

  assign en          = !vo_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      dv_v_q <= '0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      dv_v_q <= {dv_v_q[QW-1:0], v4_q};
      va_q   <= dv_v_q[QW];
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vo_q   <= vc_q;
    end
  end

  always_comb begin
    dot1 = SW'(s2_pa_q) + SW'(s2_pb_q);
    dot2 = SW'(s2_pc_q) + SW'(s2_pd_q);
    len2 = SW'(s2_pe_q) + SW'(s2_pf_q);
    s3_c_d          = '0;
    s3_c_d.px       = s2_px_q;
    s3_c_d.py       = s2_py_q;
    s3_c_d.rsq      = s2_rsq_q;
    s3_c_d.negx     = s2_dx_q[DW-1];
    s3_c_d.negy     = s2_dy_q[DW-1];
    s3_c_d.len      = len2[LW-1:0];
    s3_c_d.base_x   = s2_sx_q;
    s3_c_d.base_y   = s2_sy_q;
    s3_c_d.region   = REGION_START;
    s3_c_d.interior = 1'b0;
    if (dot1[SW-1]) begin
      s3_c_d.region = REGION_START;
    end else if (!dot2[SW-1] && (dot2 != '0)) begin
      s3_c_d.base_x = s2_ex_q;
      s3_c_d.base_y = s2_ey_q;
      s3_c_d.region = REGION_END;
    end else if (len2 == '0) begin
      // A zero-length segment falls back to its start.
      s3_c_d.region = REGION_START;
    end else begin
      s3_c_d.region   = REGION_INTERIOR;
      s3_c_d.interior = 1'b1;
    end
  end

  assign numx = NW'(s4_lox_q) + (NW'(s4_hix_q) << LO_W);
  assign numy = NW'(s4_loy_q) + (NW'(s4_hiy_q) << LO_W);

  always_comb begin
    cf   = dv_c_q[QW];
    offx = cf.negx ? -$signed({1'b0, dv_qx_q[QW]}) : $signed({1'b0, dv_qx_q[QW]});
    offy = cf.negy ? -$signed({1'b0, dv_qy_q[QW]}) : $signed({1'b0, dv_qy_q[QW]});
    if (cf.interior) begin
      na_x_d = CW'(DW'(cf.base_x) + offx);
      na_y_d = CW'(DW'(cf.base_y) + offy);
    end else begin
      na_x_d = cf.base_x;
      na_y_d = cf.base_y;
    end
  end

  always_comb begin
    dsq                 = SW'(unsigned'(sc_sqx_q)) + SW'(unsigned'(sc_sqy_q));
    out_d.nearest_x     = sc_nx_q;
    out_d.nearest_y     = sc_ny_q;
    out_d.region        = sc_region_q;
    out_d.dist_squared  = (dsq[SW-1:DISTW] != '0) ? '1 : dsq[DISTW-1:0];
    out_d.hits_disc     = dsq < SW'(sc_rsq_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q  <= DW'(in_data_i.end_x) - DW'(in_data_i.start_x);
      s1_dy_q  <= DW'(in_data_i.end_y) - DW'(in_data_i.start_y);
      s1_ax_q  <= DW'(in_data_i.point_x) - DW'(in_data_i.start_x);
      s1_ay_q  <= DW'(in_data_i.point_y) - DW'(in_data_i.start_y);
      s1_bx_q  <= DW'(in_data_i.point_x) - DW'(in_data_i.end_x);
      s1_by_q  <= DW'(in_data_i.point_y) - DW'(in_data_i.end_y);
      s1_sx_q  <= in_data_i.start_x;
      s1_sy_q  <= in_data_i.start_y;
      s1_ex_q  <= in_data_i.end_x;
      s1_ey_q  <= in_data_i.end_y;
      s1_px_q  <= in_data_i.point_x;
      s1_py_q  <= in_data_i.point_y;
      s1_rad_q <= in_data_i.radius;

      s2_pa_q  <= s1_ax_q * s1_dx_q;
      s2_pb_q  <= s1_ay_q * s1_dy_q;
      s2_pc_q  <= s1_bx_q * s1_dx_q;
      s2_pd_q  <= s1_by_q * s1_dy_q;
      s2_pe_q  <= s1_dx_q * s1_dx_q;
      s2_pf_q  <= s1_dy_q * s1_dy_q;
      s2_rsq_q <= RSQW'(s1_rad_q) * RSQW'(s1_rad_q);
      s2_dx_q  <= s1_dx_q;
      s2_dy_q  <= s1_dy_q;
      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_ex_q  <= s1_ex_q;
      s2_ey_q  <= s1_ey_q;
      s2_px_q  <= s1_px_q;
      s2_py_q  <= s1_py_q;

      // Only the interior case uses the dot, and there it lies in [0, len2].
      s3_c_q    <= s3_c_d;
      s3_dot_q  <= dot1[LW-1:0];
      s3_magx_q <= s2_dx_q[DW-1] ? CW'(-s2_dx_q) : CW'(s2_dx_q);
      s3_magy_q <= s2_dy_q[DW-1] ? CW'(-s2_dy_q) : CW'(s2_dy_q);

      s4_lox_q <= (LO_W+CW)'(s3_dot_q[LO_W-1:0]) * (LO_W+CW)'(s3_magx_q);
      s4_hix_q <= (HI_W+CW)'(s3_dot_q[LW-1:LO_W]) * (HI_W+CW)'(s3_magx_q);
      s4_loy_q <= (LO_W+CW)'(s3_dot_q[LO_W-1:0]) * (LO_W+CW)'(s3_magy_q);
      s4_hiy_q <= (HI_W+CW)'(s3_dot_q[LW-1:LO_W]) * (HI_W+CW)'(s3_magy_q);
      s4_c_q   <= s3_c_q;

      // The quotient is below 2^QW, so the top dividend bits start below len2.
      dv_remx_q[0] <= RW'(numx[NW-1:QW]);
      dv_remy_q[0] <= RW'(numy[NW-1:QW]);
      dv_lowx_q[0] <= numx[QW-1:0];
      dv_lowy_q[0] <= numy[QW-1:0];
      dv_qx_q[0]   <= '0;
      dv_qy_q[0]   <= '0;
      dv_c_q[0]    <= s4_c_q;
      for (int k = 1; k <= QW; k++) begin
        logic [RW:0] rx, ry;
        rx = div_step(dv_remx_q[k-1], dv_lowx_q[k-1][QW-1], dv_c_q[k-1].len);
        ry = div_step(dv_remy_q[k-1], dv_lowy_q[k-1][QW-1], dv_c_q[k-1].len);
        dv_remx_q[k] <= rx[RW-1:0];
        dv_remy_q[k] <= ry[RW-1:0];
        dv_lowx_q[k] <= dv_lowx_q[k-1] << 1;
        dv_lowy_q[k] <= dv_lowy_q[k-1] << 1;
        dv_qx_q[k]   <= {dv_qx_q[k-1][QW-2:0], rx[RW]};
        dv_qy_q[k]   <= {dv_qy_q[k-1][QW-2:0], ry[RW]};
        dv_c_q[k]    <= dv_c_q[k-1];
      end

      sa_nx_q     <= na_x_d;
      sa_ny_q     <= na_y_d;
      sa_px_q     <= cf.px;
      sa_py_q     <= cf.py;
      sa_rsq_q    <= cf.rsq;
      sa_region_q <= cf.region;

      sb_ddx_q    <= DW'(sa_px_q) - DW'(sa_nx_q);
      sb_ddy_q    <= DW'(sa_py_q) - DW'(sa_ny_q);
      sb_nx_q     <= sa_nx_q;
      sb_ny_q     <= sa_ny_q;
      sb_rsq_q    <= sa_rsq_q;
      sb_region_q <= sa_region_q;

      sc_sqx_q    <= sb_ddx_q * sb_ddx_q;
      sc_sqy_q    <= sb_ddy_q * sb_ddy_q;
      sc_nx_q     <= sb_nx_q;
      sc_ny_q     <= sb_ny_q;
      sc_rsq_q    <= sb_rsq_q;
      sc_region_q <= sb_region_q;

      out_q <= out_d;
    end
  end

endmodule

// ===== hdl/snpd_checker.sv =====
// Port-level checker for the segment nearest point block, bound to the top.
// Depends on snpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module snpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input snpd_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input snpd_pkg::out_t out_data_o
);
  import snpd_pkg::*;

  logic in_stall;
  logic out_stall;
  logic region_ok;

  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign region_ok = (out_data_o.region == REGION_START) ||
                     (out_data_o.region == REGION_END) ||
                     (out_data_o.region == REGION_INTERIOR);

  // The pipe only refuses input while the output beat is held back.
  `SNPD_ASSERT(a_ready_stall, clk_i, rst_ni, !in_ready_o |-> out_stall)

  // A refused input beat is held steady by the source.
  `SNPD_ASSERT(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_data_i))

  `SNPD_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o))

  `SNPD_ASSERT(a_region_code, clk_i, rst_ni, out_valid_o |-> region_ok)

  // A hit means the distance is below radius squared, so it never saturates.
  `SNPD_ASSERT(a_hit_small, clk_i, rst_ni, out_valid_o && out_data_o.hits_disc |-> out_data_o.dist_squared[DISTW-1:RSQW] == '0)

endmodule

bind segment_nearest_point_disc_test snpd_checker u_snpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
